// ===== src/lpag_pkg.sv =====
// Shared types and constants for the line pixel address generator.
// No dependencies; imported by every module of the block.
package lpag_pkg;

  // Coordinate and field widths
  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int PITCH_BITS = 15;
  localparam int COLOR_BITS = 24;
  localparam int ADDR_BITS  = 24;
  localparam int CFG_BITS   = 24;
  localparam int BPP_SHIFT  = 2;  // four bytes per pixel

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COLOR = 1'd1;

  // Request actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Reset values of the configuration registers
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = 15'd4000;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFF0000;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One rasterized pixel passed from the stepper to the address stage
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pix_t;

endpackage

// ===== src/line_pixel_address_generator_unit.sv =====
// Top level of the Bresenham line pixel address generator.
// Depends on lpag_pkg, lpag_stepper and lpag_addr.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in_     | in_valid / in_ready  | action, start_x, start_y, end_x, end_y
//   out_    | out_valid / out_ready| pixel_x, pixel_y, byte_address, color,
//           |                      | last_pixel
//   cfg_    | cfg_write_en         | cfg_index, cfg_wdata
//
// One request per cycle unless stalled. A step request passes the stepper's
// pixel register (line state update), then the address stage's result register
// (y*pitch multiply). Load requests and steps with no active line yield
// nothing. When out_ready is low with a result waiting, both stages hold and
// in_ready drops. Reset (rst_n, synchronous) clears the line and both valids.
module line_pixel_address_generator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [lpag_pkg::COORD_BITS-1:0]   in_start_x,
  input  logic [lpag_pkg::COORD_BITS-1:0]   in_start_y,
  input  logic [lpag_pkg::COORD_BITS-1:0]   in_end_x,
  input  logic [lpag_pkg::COORD_BITS-1:0]   in_end_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lpag_pkg::COORD_BITS-1:0]   out_pixel_x,
  output logic [lpag_pkg::COORD_BITS-1:0]   out_pixel_y,
  output logic [lpag_pkg::ADDR_BITS-1:0]    out_byte_address,
  output logic [lpag_pkg::COLOR_BITS-1:0]   out_color,
  output logic                              out_last_pixel,
  input  logic                              cfg_write_en,
  input  logic [lpag_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lpag_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import lpag_pkg::*;

  logic                  en;
  logic                  req_accept;
  logic                  pix_valid;
  pix_t                  pix;
  logic [PITCH_BITS-1:0] pitch_r;
  logic [COLOR_BITS-1:0] color_r;

  // Pipeline advances unless a result is waiting and not taken
  assign en         = !out_valid || out_ready;
  assign in_ready   = en;
  assign req_accept = in_valid && en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
      color_r <= COLOR_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ROW_PITCH:  pitch_r <= cfg_wdata[PITCH_BITS-1:0];
        REG_DRAW_COLOR: color_r <= cfg_wdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  lpag_stepper u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .req_accept (req_accept),
    .action     (in_action),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .pix_valid  (pix_valid),
    .pix        (pix)
  );

  lpag_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pitch     (pitch_r),
    .color     (color_r),
    .res_valid (out_valid),
    .res_x     (out_pixel_x),
    .res_y     (out_pixel_y),
    .res_addr  (out_byte_address),
    .res_color (out_color),
    .res_last  (out_last_pixel)
  );

endmodule

// ===== src/lpag_stepper.sv =====
// Bresenham line state and per-request stepping, with a registered pixel output.
// Depends on lpag_pkg.
module lpag_stepper (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             req_accept,
  input  logic             action,
  input  lpag_pkg::coord_t start_x,
  input  lpag_pkg::coord_t start_y,
  input  lpag_pkg::coord_t end_x,
  input  lpag_pkg::coord_t end_y,
  output logic             pix_valid,
  output lpag_pkg::pix_t   pix
);
  import lpag_pkg::*;

  // Line state
  logic                       active_r, active_nxt;
  logic                       swapped_r, swapped_nxt;
  coord_t                     major_pos_r, major_pos_nxt;
  coord_t                     minor_pos_r, minor_pos_nxt;
  coord_t                     major_end_r, major_end_nxt;
  logic                       major_neg_r, major_neg_nxt;
  logic                       minor_neg_r, minor_neg_nxt;
  coord_t                     major_delta_r, major_delta_nxt;
  coord_t                     minor_delta_r, minor_delta_nxt;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;

  // Pixel register
  logic pix_valid_r, pix_valid_nxt;
  pix_t pix_r, pix_nxt;

  // Load-side terms
  logic   x_neg, y_neg, steep;
  coord_t dx, dy;

  // Step-side terms
  logic signed [ERR_BITS-1:0] err_sub;
  coord_t                     step_major, step_minor;
  logic                       step_last;

  // Extents and directions of a newly loaded line
  always_comb begin
    x_neg = end_x < start_x;
    y_neg = end_y < start_y;
    dx    = x_neg ? (start_x - end_x) : (end_x - start_x);
    dy    = y_neg ? (start_y - end_y) : (end_y - start_y);
    steep = dy > dx;
  end

  // One Bresenham step from the current state
  always_comb begin
    step_major = major_neg_r ? (major_pos_r - 1'b1) : (major_pos_r + 1'b1);
    err_sub    = err_r - $signed({2'b00, minor_delta_r});
    step_minor = minor_neg_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
    step_last  = step_major == major_end_r;
  end

  // Next state and pixel
  always_comb begin
    active_nxt      = active_r;
    swapped_nxt     = swapped_r;
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    major_end_nxt   = major_end_r;
    major_neg_nxt   = major_neg_r;
    minor_neg_nxt   = minor_neg_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    err_nxt         = err_r;
    pix_valid_nxt   = 1'b0;
    pix_nxt         = pix_r;

    if (req_accept && action == ACT_LOAD) begin
      swapped_nxt = steep;
      if (steep) begin
        major_pos_nxt   = start_y;
        minor_pos_nxt   = start_x;
        major_end_nxt   = end_y;
        major_neg_nxt   = y_neg;
        minor_neg_nxt   = x_neg;
        major_delta_nxt = dy;
        minor_delta_nxt = dx;
      end else begin
        major_pos_nxt   = start_x;
        minor_pos_nxt   = start_y;
        major_end_nxt   = end_x;
        major_neg_nxt   = x_neg;
        minor_neg_nxt   = y_neg;
        major_delta_nxt = dx;
        minor_delta_nxt = dy;
      end
      err_nxt    = $signed({3'b000, major_delta_nxt[COORD_BITS-1:1]});
      active_nxt = major_delta_nxt != '0;
    end else if (req_accept && action == ACT_STEP && active_r) begin
      major_pos_nxt = step_major;
      if (err_sub < 0) begin
        minor_pos_nxt = step_minor;
        err_nxt       = err_sub + $signed({2'b00, major_delta_r});
      end else begin
        err_nxt = err_sub;
      end
      if (step_last) begin
        active_nxt = 1'b0;
      end
      pix_valid_nxt = 1'b1;
      pix_nxt.x     = swapped_r ? minor_pos_nxt : step_major;
      pix_nxt.y     = swapped_r ? step_major : minor_pos_nxt;
      pix_nxt.last  = step_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pix_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (en) begin
        pix_valid_r <= pix_valid_nxt;
      end
    end
  end

  // Line registers and pixel payload
  always_ff @(posedge clk) begin
    swapped_r     <= swapped_nxt;
    major_pos_r   <= major_pos_nxt;
    minor_pos_r   <= minor_pos_nxt;
    major_end_r   <= major_end_nxt;
    major_neg_r   <= major_neg_nxt;
    minor_neg_r   <= minor_neg_nxt;
    major_delta_r <= major_delta_nxt;
    minor_delta_r <= minor_delta_nxt;
    err_r         <= err_nxt;
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;

endmodule

// ===== src/lpag_addr.sv =====
// Byte address computation (x*4 + y*pitch) and the result register.
// Depends on lpag_pkg.
module lpag_addr (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                pix_valid,
  input  lpag_pkg::pix_t                      pix,
  input  logic [lpag_pkg::PITCH_BITS-1:0]     pitch,
  input  logic [lpag_pkg::COLOR_BITS-1:0]     color,
  output logic                                res_valid,
  output lpag_pkg::coord_t                    res_x,
  output lpag_pkg::coord_t                    res_y,
  output logic [lpag_pkg::ADDR_BITS-1:0]      res_addr,
  output logic [lpag_pkg::COLOR_BITS-1:0]     res_color,
  output logic                                res_last
);
  import lpag_pkg::*;

  localparam int PROD_BITS = COORD_BITS + PITCH_BITS;

  logic                           valid_r;
  coord_t                         x_r, y_r;
  logic [ADDR_BITS-1:0]           addr_r, addr_nxt;
  logic [COLOR_BITS-1:0]          color_r;
  logic                           last_r;
  logic [PROD_BITS-1:0]           row_off;
  logic [ADDR_BITS-1:0]           col_off;

  // Row offset by one narrow multiply, column offset by a shift; wraps at 2^24
  always_comb begin
    row_off  = PROD_BITS'(pix.y) * PROD_BITS'(pitch);
    col_off  = ADDR_BITS'({pix.x, {BPP_SHIFT{1'b0}}});
    addr_nxt = col_off + row_off[ADDR_BITS-1:0];
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pix_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= pix.x;
      y_r     <= pix.y;
      addr_r  <= addr_nxt;
      color_r <= color;
      last_r  <= pix.last;
    end
  end

  assign res_valid = valid_r;
  assign res_x     = x_r;
  assign res_y     = y_r;
  assign res_addr  = addr_r;
  assign res_color = color_r;
  assign res_last  = last_r;

endmodule
